@@ sv/rau_pkg.sv @@
// Shared types and codes for the rational arithmetic unit.
// No dependencies; the top level, rau_gcd and the testbench use this package.
package rau_pkg;

  localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_LT  = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  // which fraction the shared reduction path is working on
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_R = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic               compare_true;
    logic [1:0]         status;
  } rau_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NSTART, S_NGCD, S_NDIVN, S_NDIVD,
    S_NCHK, S_OPER, S_MUL, S_COMB, S_OUT
  } rau_state_e;

  typedef enum logic [1:0] {
    GCD_IDLE, GCD_TWOS, GCD_ODDU, GCD_LOOP
  } gcd_state_e;

endpackage

@@ sv/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer and shared datapath.
// Depends on rau_pkg, rau_mul, rau_div and rau_gcd.
//
// Usage: an item on the in channel (valid/ready) carries an operation and
// two fractions; one result item leaves on the out channel (valid/ready).
// The core handles one item at a time: in_ready_o is high only while idle.
// Each operand, then the arithmetic result, is reduced through one shared
// binary gcd unit (one shift or subtract per cycle) and one shared restoring
// divider (two divisions per reduction).
// The cross products go through one registered multiplier, one at a time.
// A zero denominator goes straight to the output; a zero numerator skips the
// gcd and the divider. An item reduces two fractions for a compare and three
// for arithmetic; the gcd and divider iterations set how long each one takes.
// The core restarts only from idle.
// A finished result moves to an output register, so the core takes the next
// item while the receiver stalls; a second result waits in the core, and
// in_ready_o stays low until the output register frees up.
// Reset is asynchronous, active low, and returns the block to idle, empty.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rau_pkg::rau_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rau_pkg::rau_out_t out_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned WW = 2 * VALUE_WIDTH;
  localparam int unsigned MW = VALUE_WIDTH - 1;
  localparam logic [WW-1:0] LIM = WW'({MW{1'b1}});

  rau_pkg::rau_state_e state_q, state_d;
  rau_pkg::rau_in_t    in_q, in_d;
  rau_pkg::rau_out_t   out_q, out_d;
  rau_pkg::rau_out_t   res_q, res_d;
  logic                res_vld_q, res_vld_d;

  logic [1:0]    sel_q, sel_d;
  logic          nsign_q, nsign_d;
  logic [WW-1:0] nmag_q, nmag_d, dmag_q, dmag_d;
  logic [WW-1:0] g_q, g_d, nq_q, nq_d, dq_q, dq_d;
  logic          a_s_q, a_s_d, b_s_q, b_s_d;
  logic [MW-1:0] a_n_q, a_n_d, a_d_q, a_d_d, b_n_q, b_n_d, b_d_q, b_d_d;
  logic [WW-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [1:0]    mcnt_q, mcnt_d;

  // raw operands, sign extended from VALUE_WIDTH bits
  logic [WW-1:0] ax_n, ax_d, bx_n, bx_d;
  logic [WW-1:0] ra_nm, ra_dm, rb_nm, rb_dm;
  logic          zero_den, ovf;

  logic          gcd_start, gcd_done, div_start, div_done;
  logic [WW-1:0] gcd_val, div_dvd, div_dvs, div_quot;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_prod;

  logic [WW-1:0] t0, t1, comb_n;
  logic [31:0]   num_ext;

  assign ax_n = {{(WW-W){in_q.a_num[W-1]}}, in_q.a_num[W-1:0]};
  assign ax_d = {{(WW-W){in_q.a_den[W-1]}}, in_q.a_den[W-1:0]};
  assign bx_n = {{(WW-W){in_q.b_num[W-1]}}, in_q.b_num[W-1:0]};
  assign bx_d = {{(WW-W){in_q.b_den[W-1]}}, in_q.b_den[W-1:0]};

  assign ra_nm = ax_n[WW-1] ? ~ax_n + 1'b1 : ax_n;
  assign ra_dm = ax_d[WW-1] ? ~ax_d + 1'b1 : ax_d;
  assign rb_nm = bx_n[WW-1] ? ~bx_n + 1'b1 : bx_n;
  assign rb_dm = bx_d[WW-1] ? ~bx_d + 1'b1 : bx_d;

  assign zero_den = (ra_nm != '0 && ra_dm == '0) || (rb_nm != '0 && rb_dm == '0);
  assign ovf      = (nq_q > LIM) || (dq_q > LIM);

  // signed combination of the cross products
  assign t0 = a_s_q ? ~p0_q + 1'b1 : p0_q;
  assign t1 = b_s_q ? ~p1_q + 1'b1 : p1_q;
  assign comb_n = (in_q.operation == rau_pkg::OP_ADD) ? t0 + t1 : t0 - t1;

  assign num_ext = 32'(nq_q[MW-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::S_IDLE:   if (in_valid_i) state_d = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK:  state_d = zero_den ? rau_pkg::S_OUT : rau_pkg::S_NSTART;
      rau_pkg::S_NSTART: state_d = (nmag_q == '0) ? rau_pkg::S_NCHK : rau_pkg::S_NGCD;
      rau_pkg::S_NGCD:   if (gcd_done) state_d = rau_pkg::S_NDIVN;
      rau_pkg::S_NDIVN:  if (div_done) state_d = rau_pkg::S_NDIVD;
      rau_pkg::S_NDIVD:  if (div_done) state_d = rau_pkg::S_NCHK;
      rau_pkg::S_NCHK: begin
        if (ovf) begin
          state_d = rau_pkg::S_OUT;
        end else begin
          unique case (sel_q)
            rau_pkg::SEL_A: state_d = rau_pkg::S_NSTART;
            rau_pkg::SEL_B: state_d = rau_pkg::S_OPER;
            default:        state_d = rau_pkg::S_OUT;
          endcase
        end
      end
      rau_pkg::S_OPER: begin
        unique case (in_q.operation) inside
          rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_LT:
            state_d = rau_pkg::S_MUL;
          rau_pkg::OP_DIV:
            state_d = (b_n_q == '0) ? rau_pkg::S_OUT : rau_pkg::S_MUL;
          default:
            state_d = rau_pkg::S_OUT;
        endcase
      end
      rau_pkg::S_MUL:  if (mcnt_q == 2'd3) state_d = rau_pkg::S_COMB;
      rau_pkg::S_COMB:
        state_d = (in_q.operation == rau_pkg::OP_LT) ? rau_pkg::S_OUT : rau_pkg::S_NSTART;
      // hand the result over once the output register is free
      rau_pkg::S_OUT:  if (!res_vld_q || out_ready_i) state_d = rau_pkg::S_IDLE;
      default:         state_d = rau_pkg::S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    in_d    = in_q;
    out_d   = out_q;
    sel_d   = sel_q;
    nsign_d = nsign_q;
    nmag_d  = nmag_q;
    dmag_d  = dmag_q;
    g_d     = g_q;
    nq_d    = nq_q;
    dq_d    = dq_q;
    a_s_d   = a_s_q;
    a_n_d   = a_n_q;
    a_d_d   = a_d_q;
    b_s_d   = b_s_q;
    b_n_d   = b_n_q;
    b_d_d   = b_d_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    mcnt_d  = mcnt_q;
    gcd_start = 1'b0;
    div_start = 1'b0;
    div_dvd   = nmag_q;
    div_dvs   = gcd_val;
    mul_a     = a_n_q;
    mul_b     = b_d_q;
    unique case (state_q)
      rau_pkg::S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_i;
          out_d.result_num   = '0;
          out_d.result_den   = 31'd1;
          out_d.compare_true = 1'b0;
          out_d.status       = rau_pkg::STAT_OK;
        end
      end
      rau_pkg::S_CHECK: begin
        if (zero_den) begin
          out_d.status = rau_pkg::STAT_ZERO_DEN;
        end else begin
          sel_d   = rau_pkg::SEL_A;
          nsign_d = ax_n[WW-1] ^ ax_d[WW-1];
          nmag_d  = ra_nm;
          dmag_d  = ra_dm;
        end
      end
      rau_pkg::S_NSTART: begin
        if (nmag_q == '0) begin
          nq_d    = '0;
          dq_d    = WW'(1);
          nsign_d = 1'b0;
        end else begin
          gcd_start = 1'b1;
        end
      end
      rau_pkg::S_NGCD: begin
        if (gcd_done) begin
          g_d       = gcd_val;
          div_start = 1'b1;
        end
      end
      rau_pkg::S_NDIVN: begin
        div_dvd = dmag_q;
        div_dvs = g_q;
        if (div_done) begin
          nq_d      = div_quot;
          div_start = 1'b1;
        end
      end
      rau_pkg::S_NDIVD: begin
        if (div_done) dq_d = div_quot;
      end
      rau_pkg::S_NCHK: begin
        if (ovf) begin
          out_d.status = rau_pkg::STAT_OVERFLOW;
        end else begin
          unique case (sel_q)
            rau_pkg::SEL_A: begin
              a_s_d   = nsign_q;
              a_n_d   = nq_q[MW-1:0];
              a_d_d   = dq_q[MW-1:0];
              sel_d   = rau_pkg::SEL_B;
              nsign_d = bx_n[WW-1] ^ bx_d[WW-1];
              nmag_d  = rb_nm;
              dmag_d  = rb_dm;
            end
            rau_pkg::SEL_B: begin
              b_s_d = nsign_q;
              b_n_d = nq_q[MW-1:0];
              b_d_d = dq_q[MW-1:0];
            end
            default: begin
              out_d.result_num = signed'(nsign_q ? ~num_ext + 1'b1 : num_ext);
              out_d.result_den = 31'(dq_q[MW-1:0]);
            end
          endcase
        end
      end
      rau_pkg::S_OPER: begin
        mcnt_d = '0;
        if (in_q.operation == rau_pkg::OP_DIV && b_n_q == '0)
          out_d.status = rau_pkg::STAT_DIV_ZERO;
        if (in_q.operation == rau_pkg::OP_EQ)
          out_d.compare_true = (a_s_q == b_s_q) && (a_n_q == b_n_q) && (a_d_q == b_d_q);
      end
      rau_pkg::S_MUL: begin
        mcnt_d = mcnt_q + 1'b1;
        case (mcnt_q)
          2'd0: begin
            mul_a = a_n_q;
            mul_b = (in_q.operation == rau_pkg::OP_MUL) ? b_n_q : b_d_q;
          end
          2'd1: begin
            mul_a = b_n_q;
            mul_b = a_d_q;
          end
          default: begin
            mul_a = a_d_q;
            mul_b = (in_q.operation == rau_pkg::OP_DIV) ? b_n_q : b_d_q;
          end
        endcase
        case (mcnt_q)
          2'd1:    p0_d = WW'(mul_prod);
          2'd2:    p1_d = WW'(mul_prod);
          2'd3:    p2_d = WW'(mul_prod);
          default: ;
        endcase
      end
      rau_pkg::S_COMB: begin
        sel_d  = rau_pkg::SEL_R;
        dmag_d = p2_q;
        case (in_q.operation) inside
          rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
            nsign_d = a_s_q ^ b_s_q;
            nmag_d  = p0_q;
          end
          rau_pkg::OP_LT: begin
            out_d.compare_true = comb_n[WW-1];
          end
          default: begin
            nsign_d = comb_n[WW-1];
            nmag_d  = comb_n[WW-1] ? ~comb_n + 1'b1 : comb_n;
          end
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    res_d     = res_q;
    res_vld_d = res_vld_q;
    if (res_vld_q && out_ready_i) res_vld_d = 1'b0;
    if (state_q == rau_pkg::S_OUT && (!res_vld_q || out_ready_i)) begin
      res_d     = out_q;
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rau_pkg::S_IDLE;
      sel_q     <= rau_pkg::SEL_A;
      mcnt_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      mcnt_q    <= mcnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    out_q   <= out_d;
    res_q   <= res_d;
    nsign_q <= nsign_d;
    nmag_q  <= nmag_d;
    dmag_q  <= dmag_d;
    g_q     <= g_d;
    nq_q    <= nq_d;
    dq_q    <= dq_d;
    a_s_q   <= a_s_d;
    a_n_q   <= a_n_d;
    a_d_q   <= a_d_d;
    b_s_q   <= b_s_d;
    b_n_q   <= b_n_d;
    b_d_q   <= b_d_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
  end

  rau_gcd #(.WIDTH(WW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .u_i     (nmag_q),
    .v_i     (dmag_q),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  rau_div #(.WIDTH(WW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rau_mul #(.WIDTH(MW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  assign in_ready_o  = (state_q == rau_pkg::S_IDLE);
  assign out_valid_o = res_vld_q;
  assign out_o       = res_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result item changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != rau_pkg::STAT_OK |->
      out_o.result_num == '0 && out_o.result_den == 31'd1 && !out_o.compare_true)
    else $error("error result not cleared");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.result_den != '0)
    else $error("zero result denominator");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_start |-> nmag_q != '0 && dmag_q != '0)
    else $error("gcd started on zero");

endmodule

@@ sv/rau_mul.sv @@
// Registered unsigned multiplier shared by all cross products.
// Depends on nothing outside this file.
module rau_mul #(
  parameter int unsigned WIDTH = 31
) (
  input  logic                 clk_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [2*WIDTH-1:0]   prod_o
);

  logic [2*WIDTH-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (2*WIDTH)'(a_i) * (2*WIDTH)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ sv/rau_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module rau_div #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic [WIDTH:0]   trial;
  logic             qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[WIDTH-1]};
    qbit   = trial >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? WIDTH'(trial - {1'b0, dvs_q}) : trial[WIDTH-1:0];
      dvd_d = {dvd_q[WIDTH-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ sv/rau_gcd.sv @@
// Binary gcd unit: one shift or subtract per cycle. Both inputs nonzero.
// Depends on rau_pkg for its state type.
module rau_gcd #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] u_i,
  input  logic [WIDTH-1:0] v_i,
  output logic             done_o,
  output logic [WIDTH-1:0] gcd_o
);

  localparam int unsigned KW = $clog2(WIDTH);

  rau_pkg::gcd_state_e state_q, state_d;
  logic [WIDTH-1:0] u_q, u_d, v_q, v_d;
  logic [KW-1:0]    k_q, k_d;
  logic             done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rau_pkg::GCD_IDLE: if (start_i) state_d = rau_pkg::GCD_TWOS;
      rau_pkg::GCD_TWOS: if (u_q[0] || v_q[0]) state_d = rau_pkg::GCD_ODDU;
      rau_pkg::GCD_ODDU: if (u_q[0]) state_d = rau_pkg::GCD_LOOP;
      rau_pkg::GCD_LOOP: if (v_q == '0) state_d = rau_pkg::GCD_IDLE;
      default:           state_d = rau_pkg::GCD_IDLE;
    endcase
  end

  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    k_d    = k_q;
    done_d = 1'b0;
    unique case (state_q)
      rau_pkg::GCD_IDLE: begin
        if (start_i) begin
          u_d = u_i;
          v_d = v_i;
          k_d = '0;
        end
      end
      rau_pkg::GCD_TWOS: begin
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end
      end
      rau_pkg::GCD_ODDU: begin
        if (!u_q[0]) u_d = u_q >> 1;
      end
      rau_pkg::GCD_LOOP: begin
        // u stays odd; v shrinks until it hits zero
        if (v_q == '0) begin
          done_d = 1'b1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = v_q;
          v_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::GCD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
  end

  assign done_o = done_q;
  assign gcd_o  = u_q << k_q;

endmodule

@@ bench/tb_rational_arithmetic_unit.sv @@
// Testbench for rational_arithmetic_unit: directed and random fraction items,
// each checked against a built-in fraction predictor.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb_rational_arithmetic_unit;

  // codes that the package leaves unnamed
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam longint LIMIT = 64'sd2147483647;
  localparam int MAX_CYCLES = 12000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  rau_pkg::rau_in_t  in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rau_pkg::rau_out_t out_o;

  rau_pkg::rau_out_t expected_q[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  int       cycles = 0;
  int       errors = 0;
  int       items_sent = 0;
  int       results_seen = 0;

  rational_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Lowest terms with positive denominator; returns status.
  function automatic logic [1:0] reduce_frac(input longint n, input longint d,
                                             output longint rn, output longint rd);
    logic neg;
    longint unsigned mn, md, x, y, t;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    rn = 0;
    rd = 1;
    if (mn == 0) begin
      md = 1;
      neg = 1'b0;
    end
    if (md == 0) return rau_pkg::STAT_ZERO_DEN;
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mn = mn / x;
    md = md / x;
    if (mn > LIMIT || md > LIMIT) return rau_pkg::STAT_OVERFLOW;
    rn = neg ? -longint'(mn) : longint'(mn);
    rd = longint'(md);
    return rau_pkg::STAT_OK;
  endfunction

  function automatic rau_pkg::rau_out_t predict_fraction(input rau_pkg::rau_in_t it);
    rau_pkg::rau_out_t r;
    logic [1:0] st, st_b;
    longint an, ad, bn, bd, rn, rd;
    logic cmp;
    cmp = 1'b0;
    rn = 0;
    rd = 1;
    st = reduce_frac(longint'(it.a_num), longint'(it.a_den), an, ad);
    st_b = reduce_frac(longint'(it.b_num), longint'(it.b_den), bn, bd);
    if (st == rau_pkg::STAT_OK) st = st_b;
    else if (st_b == rau_pkg::STAT_ZERO_DEN) st = rau_pkg::STAT_ZERO_DEN;
    if (st == rau_pkg::STAT_OK) begin
      case (it.operation)
        rau_pkg::OP_ADD: st = reduce_frac(an * bd + bn * ad, ad * bd, rn, rd);
        rau_pkg::OP_SUB: st = reduce_frac(an * bd - bn * ad, ad * bd, rn, rd);
        rau_pkg::OP_MUL: st = reduce_frac(an * bn, ad * bd, rn, rd);
        rau_pkg::OP_DIV: begin
          if (bn == 0) st = rau_pkg::STAT_DIV_ZERO;
          else st = reduce_frac(an * bd, ad * bn, rn, rd);
        end
        rau_pkg::OP_EQ: cmp = (an == bn) && (ad == bd);
        rau_pkg::OP_LT: cmp = (an * bd - bn * ad) < 0;
        default: ;
      endcase
    end
    if (st != rau_pkg::STAT_OK) begin
      rn = 0;
      rd = 1;
      cmp = 1'b0;
    end
    r.result_num = rn[31:0];
    r.result_den = rd[30:0];
    r.compare_true = cmp;
    r.status = st;
    return r;
  endfunction

  // receiver: random stalls, long hold-off on request, result checking
  always @(posedge clk_i) begin
    rau_pkg::rau_out_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d", $time, out_o.result_num,
                 out_o.result_den);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (want !== out_o) begin
          errors++;
          $display("%0t: mismatch exp num=%0d den=%0d cmp=%0b st=%0d", $time,
                   want.result_num, want.result_den, want.compare_true, want.status);
          $display("%0t:          got num=%0d den=%0d cmp=%0b st=%0d", $time,
                   out_o.result_num, out_o.result_den, out_o.compare_true, out_o.status);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input rau_pkg::rau_in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_fraction(it));
    items_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic rau_pkg::rau_in_t make_item(input logic [2:0] op, input int an,
                                                 input int ad, input int bn, input int bd);
    rau_pkg::rau_in_t it;
    it.operation = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  function automatic logic [31:0] rand_value(input bit is_den);
    case ($urandom_range(9))
      0, 1, 2: return 32'($signed($urandom_range(40)) - 20);
      3, 4: return 32'($signed($urandom_range(2000)) - 1000);
      5: return 32'($signed($urandom_range(131072)) - 65536);
      6: begin
        case ($urandom_range(5))
          0: return 32'h7fffffff;
          1: return 32'h80000001;
          2: return 32'h80000000;
          3: return is_den ? 32'd0 : 32'd1;
          4: return 32'hffffffff;
          default: return 32'h40000000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_item(make_item(rau_pkg::OP_ADD, 1, 2, 1, 3));
    send_item(make_item(rau_pkg::OP_SUB, 1, 3, 1, 2));
    send_item(make_item(rau_pkg::OP_MUL, -2, 3, 3, -4));
    send_item(make_item(rau_pkg::OP_DIV, 3, 4, -3, 8));
    send_item(make_item(rau_pkg::OP_EQ, 2, 4, -1, -2));
    send_item(make_item(rau_pkg::OP_EQ, 1, 2, 1, 3));
    send_item(make_item(rau_pkg::OP_LT, -1, 2, 1, 3));
    send_item(make_item(rau_pkg::OP_LT, 1, 2, 1, 3));
    send_item(make_item(OP_SPARE6, 5, 7, 2, 9));
    send_item(make_item(OP_SPARE7, 5, 7, 2, 9));
    send_item(make_item(rau_pkg::OP_ADD, 0, 0, 0, 0));             // 0/0 is zero
    send_item(make_item(rau_pkg::OP_ADD, 3, 0, 1, 2));             // zero denominator left
    send_item(make_item(rau_pkg::OP_EQ, 1, 2, -5, 0));             // zero denominator right
    send_item(make_item(rau_pkg::OP_DIV, 1, 2, 0, 7));             // divide by zero
    send_item(make_item(rau_pkg::OP_MUL, 32'h80000000, 1, 1, 1));  // operand too large
    send_item(make_item(rau_pkg::OP_LT, 32'h80000000, 1, 3, 0));   // zero den wins
    send_item(make_item(rau_pkg::OP_ADD, 32'h7fffffff, 1, 32'h7fffffff, 1));  // overflow
    send_item(make_item(rau_pkg::OP_MUL, 1, 32'h7fffffff, 1, 32'h7fffffff));
    send_item(make_item(rau_pkg::OP_SUB, 32'h7fffffff, 32'h7ffffffe, 32'h80000001,
                        32'h7fffffff));
    send_item(make_item(rau_pkg::OP_DIV, 32'h80000001, -1, 32'h7fffffff, 32'h80000001));
    send_item(make_item(rau_pkg::OP_ADD, -6, -4, 32'hffffffff, 32'hffffffff));
    drain();
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle,
                             input bit hold_off);
    rau_pkg::rau_in_t it;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == count / 2) hold_cycles = 3000;
      it.operation = 3'($urandom_range(7));
      it.a_num = rand_value(1'b0);
      it.a_den = rand_value(1'b1);
      it.b_num = rand_value(1'b0);
      it.b_den = rand_value(1'b1);
      send_item(it);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(540, 20, 84, 1'b0);
    test_random(540, 84, 20, 1'b0);
    test_random(550, 0, 0, 1'b1);
    $display("covered %0d items, %0d results: all operations, error statuses, extremes",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
